/* rtl/ttpt_pkg.sv */
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared types, constants and helpers of the turn profile tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttpt_pkg;

    // datapath width of the serial arithmetic units
    localparam int DW    = 64;
    localparam int CNT_W = $clog2(DW + 1);

    // profile segment limit
    localparam int MAX_SEGMENTS = 4096;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS - 1);

    // fixed point constants
    localparam logic [DW-1:0] PI_2880_Q32 = 64'd4685083;
    localparam logic [DW-1:0] USEC        = 64'd1000000;
    localparam logic [DW-1:0] USEC2       = 64'd2000000;
    localparam logic [DW-1:0] ROUND_HALF  = 64'h0000_0000_8000_0000;
    localparam logic [23:0]   DUR_MAX     = 24'hFF_FFFF;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;

    // configuration register indexes
    localparam logic [2:0] REG_TURN_ANGLE    = 3'd0;
    localparam logic [2:0] REG_CRUISE_VEL    = 3'd1;
    localparam logic [2:0] REG_MAX_ACCEL     = 3'd2;
    localparam logic [2:0] REG_TICK_PERIOD   = 3'd3;
    localparam logic [2:0] REG_HALF_BASE     = 3'd4;
    localparam logic [2:0] REG_POSITION_GAIN = 3'd5;
    localparam logic [2:0] REG_RPM_GAIN      = 3'd6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] gyro_yaw;
    } req_item_t;

    typedef struct packed {
        logic signed [15:0] left_rpm;
        logic signed [15:0] right_rpm;
        logic               finished;
    } rsp_item_t;

    // saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [42:0] x);
        logic signed [15:0] r;
        if (x > 43'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (x < -43'sd32768)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ttpt_mul.sv */
// ----------------------------------------------------------------------------
// ttpt_mul
// Bit-serial shift and add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttpt_mul (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [ttpt_pkg::DW-1:0] a,
    input  wire logic [ttpt_pkg::DW-1:0] b,
    output logic                         done,
    output logic [ttpt_pkg::DW-1:0]      prod
);

    logic [ttpt_pkg::DW-1:0] a_reg;
    logic [ttpt_pkg::DW-1:0] b_reg;
    logic [ttpt_pkg::DW-1:0] acc_reg;
    logic                    run_reg;
    logic                    done_reg;

    // shift multiplicand up, multiplier down, stop when multiplier is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (b_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* rtl/ttpt_div.sv */
// ----------------------------------------------------------------------------
// ttpt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttpt_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [ttpt_pkg::DW-1:0] num,
    input  wire logic [ttpt_pkg::DW-1:0] den,
    output logic                         done,
    output logic [ttpt_pkg::DW-1:0]      quot
);

    logic [ttpt_pkg::DW-1:0]    n_reg;
    logic [ttpt_pkg::DW-1:0]    d_reg;
    logic [ttpt_pkg::DW-1:0]    r_reg;
    logic [ttpt_pkg::CNT_W-1:0] cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [ttpt_pkg::DW:0]      r2;
    logic [ttpt_pkg::DW:0]      rsub;
    logic                       ge;

    // trial subtract of the shifted remainder
    always_comb
    begin
        r2   = {r_reg, n_reg[ttpt_pkg::DW-1]};
        rsub = r2 - {1'b0, d_reg};
        ge   = (r2 >= {1'b0, d_reg});
    end

    // quotient bits enter at the bottom as dividend bits leave the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            d_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg   <= num;
                d_reg   <= den;
                r_reg   <= '0;
                cnt_reg <= ttpt_pkg::CNT_W'(ttpt_pkg::DW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                r_reg   <= ge ? rsub[ttpt_pkg::DW-1:0] : r2[ttpt_pkg::DW-1:0];
                n_reg   <= {n_reg[ttpt_pkg::DW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ttpt_pkg::CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = n_reg;

endmodule

`default_nettype wire

/* rtl/ttpt_sqrt.sv */
// ----------------------------------------------------------------------------
// ttpt_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttpt_sqrt (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [ttpt_pkg::DW-1:0] x,
    output logic                         done,
    output logic [ttpt_pkg::DW-1:0]      root
);

    logic [ttpt_pkg::DW-1:0] x_reg;
    logic [ttpt_pkg::DW-1:0] r_reg;
    logic [ttpt_pkg::DW-1:0] bit_reg;
    logic                    run_reg;
    logic                    done_reg;
    logic [ttpt_pkg::DW:0]   trial;
    logic                    ge;

    // compare the remainder against root plus current bit
    always_comb
    begin
        trial = {1'b0, r_reg} + {1'b0, bit_reg};
        ge    = ({1'b0, x_reg} >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg   <= x;
                r_reg   <= '0;
                bit_reg <= ttpt_pkg::DW'(1) << (ttpt_pkg::DW - 2);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (bit_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (ge)
                    begin
                        x_reg <= x_reg - trial[ttpt_pkg::DW-1:0];
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg;

endmodule

`default_nettype wire

/* rtl/trapezoid_turn_profile_tracker_core.sv */
// ----------------------------------------------------------------------------
// trapezoid_turn_profile_tracker_core
// Turn-in-place trapezoidal profiler with gyro position correction.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on the req channel (valid/ready), one
// result beat per request leaves on the rsp channel. A start beat captures
// the yaw and plans the profile; each tick beat yields one wheel speed pair;
// a stop beat zeroes the speeds and idles the profiler. Registers are to be
// written through wr_en/wr_index/wr_data only while the block is idle; the
// block itself does not enforce this. A request runs as a chain of serial
// multiply, divide and square root steps on bit-serial units sharing one
// sequencer. One request is in work at a time; req_ready is high while the
// sequencer is idle, also while a result still waits. Reset clears the
// profile state and loads the register defaults. When the receiver stalls,
// the finished result is held and the sequencer waits in its output step
// after the next request has been worked through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_turn_profile_tracker_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ttpt_pkg::req_item_t req_item,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output ttpt_pkg::rsp_item_t      rsp_item,
    input  wire logic                wr_en,
    input  wire logic [2:0]          wr_index,
    input  wire logic [16:0]         wr_data
);

    localparam int DW = ttpt_pkg::DW;
    localparam int SW = ttpt_pkg::SEG_W;

    // sequencer steps
    localparam logic [5:0] ST_IDLE  = 6'd0;
    localparam logic [5:0] ST_OUT   = 6'd1;
    localparam logic [5:0] ST_P_MH  = 6'd2;
    localparam logic [5:0] ST_P_PI  = 6'd3;
    localparam logic [5:0] ST_P_DA  = 6'd4;
    localparam logic [5:0] ST_P_VV  = 6'd5;
    localparam logic [5:0] ST_T_VU  = 6'd6;
    localparam logic [5:0] ST_T_TAU = 6'd7;
    localparam logic [5:0] ST_T_AD  = 6'd8;
    localparam logic [5:0] ST_T_RU  = 6'd9;
    localparam logic [5:0] ST_T_VD  = 6'd10;
    localparam logic [5:0] ST_T_N   = 6'd11;
    localparam logic [5:0] ST_S_PK  = 6'd12;
    localparam logic [5:0] ST_S_E1  = 6'd13;
    localparam logic [5:0] ST_S_E2  = 6'd14;
    localparam logic [5:0] ST_S_E3  = 6'd15;
    localparam logic [5:0] ST_S_TAU = 6'd16;
    localparam logic [5:0] ST_P_AS  = 6'd17;
    localparam logic [5:0] ST_K_T   = 6'd18;
    localparam logic [5:0] ST_K_HV  = 6'd19;
    localparam logic [5:0] ST_K_HD  = 6'd20;
    localparam logic [5:0] ST_K_AT  = 6'd21;
    localparam logic [5:0] ST_K_AV  = 6'd22;
    localparam logic [5:0] ST_K_AVT = 6'd23;
    localparam logic [5:0] ST_K_AD  = 6'd24;
    localparam logic [5:0] ST_K_DU  = 6'd25;
    localparam logic [5:0] ST_K_DW  = 6'd26;
    localparam logic [5:0] ST_K_DWU = 6'd27;
    localparam logic [5:0] ST_K_DD  = 6'd28;
    localparam logic [5:0] ST_K_AC1 = 6'd29;
    localparam logic [5:0] ST_K_AC2 = 6'd30;
    localparam logic [5:0] ST_K_RV  = 6'd31;
    localparam logic [5:0] ST_K_CP  = 6'd32;

    // arithmetic unit select
    localparam logic [1:0] U_NONE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_SQRT = 2'd3;

    // profile phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;
    localparam logic [1:0] PH_DECEL = 2'd3;

    // sample kinds
    localparam logic [1:0] KD_ACC  = 2'd0;
    localparam logic [1:0] KD_HOLD = 2'd1;
    localparam logic [1:0] KD_DEC  = 2'd2;
    localparam logic [1:0] KD_FIN  = 2'd3;

    // configuration registers
    logic [13:0] turn_angle_reg;
    logic [15:0] cruise_reg;
    logic [15:0] accel_reg;
    logic [16:0] period_reg;
    logic [13:0] hbw_reg;
    logic [15:0] pgain_reg;
    logic [15:0] rgain_reg;

    // profile state
    logic signed [15:0] start_yaw_reg;
    logic [1:0]         phase_reg;
    logic [SW-1:0]      idx_reg;
    logic [SW-1:0]      as_reg;
    logic [SW-1:0]      hs_reg;
    logic [15:0]        peak_reg;
    logic [23:0]        adur_reg;
    logic [23:0]        ad_reg;
    logic [23:0]        total_reg;
    logic               turn_left_reg;
    logic               done_reg;

    // sequencer and working registers
    logic [5:0]         st_reg;
    logic               busy_reg;
    logic               zero_reg;
    logic signed [15:0] yaw_reg;
    logic [1:0]         kind_reg;
    logic [SW-1:0]      i_reg;
    logic [DW-1:0]      tmp_reg;
    logic [DW-1:0]      da_reg;
    logic [DW-1:0]      vv_reg;
    logic [32:0]        vd_reg;
    logic [39:0]        tau_reg;
    logic [29:0]        t_reg;
    logic [29:0]        u_reg;
    logic [15:0]        v_reg;
    logic signed [39:0] d_reg;
    logic [20:0]        act_reg;
    logic [15:0]        rvm_reg;
    logic [41:0]        cm_reg;
    logic               rsp_valid_reg;
    ttpt_pkg::rsp_item_t rsp_item_reg;

    // combinational helpers
    logic signed [13:0] ang;
    logic [13:0]        mag;
    logic [15:0]        a_nz;
    logic [15:0]        vc_nz;
    logic [16:0]        dt_nz;
    logic signed [16:0] diff;
    logic [16:0]        dmag;
    logic [23:0]        durs;
    logic signed [40:0] ds;
    logic signed [21:0] acts;
    logic signed [41:0] e_val;
    logic [41:0]        emag;
    logic signed [42:0] rvs;
    logic signed [42:0] comps;
    logic signed [42:0] total_sum;
    logic [1:0]         unit_sel;
    logic [DW-1:0]      op_a;
    logic [DW-1:0]      op_b;
    logic [DW-1:0]      res;
    logic [DW-1:0]      res_rnd;
    logic               unit_start;
    logic               unit_done;
    logic               mul_done;
    logic               div_done;
    logic               sqrt_done;
    logic [DW-1:0]      mul_prod;
    logic [DW-1:0]      div_quot;
    logic [DW-1:0]      sqrt_root;
    logic               req_acc;
    logic               out_free;

    // tick resolution
    logic [1:0]    r_kind;
    logic [SW-1:0] r_i;
    logic [1:0]    r_phase;
    logic [SW-1:0] r_idx;
    logic          r_done;
    logic [SW-1:0] i2;
    logic [SW-1:0] i3;

    assign req_ready = (st_reg == ST_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // operand conditioning
    always_comb
    begin
        ang   = $signed(turn_angle_reg);
        mag   = ang[13] ? 14'(-ang) : 14'(ang);
        a_nz  = (accel_reg == '0) ? 16'd1 : accel_reg;
        vc_nz = (cruise_reg == '0) ? 16'd1 : cruise_reg;
        dt_nz = (period_reg == '0) ? 17'd1 : period_reg;
        diff  = {yaw_reg[15], yaw_reg} - {start_yaw_reg[15], start_yaw_reg};
        dmag  = diff[16] ? 17'(-diff) : 17'(diff);
        durs  = (tau_reg > 40'(ttpt_pkg::DUR_MAX)) ? ttpt_pkg::DUR_MAX : tau_reg[23:0];
    end

    // arc error and wheel speed combination
    always_comb
    begin
        ds        = turn_left_reg ? -{d_reg[39], d_reg} : {d_reg[39], d_reg};
        acts      = diff[16] ? -$signed({1'b0, act_reg}) : $signed({1'b0, act_reg});
        e_val     = {ds[40], ds} - {{20{acts[21]}}, acts};
        emag      = e_val[41] ? 42'(-e_val) : 42'(e_val);
        rvs       = turn_left_reg ? -$signed({27'b0, rvm_reg}) : $signed({27'b0, rvm_reg});
        comps     = e_val[41] ? -$signed({1'b0, cm_reg}) : $signed({1'b0, cm_reg});
        total_sum = rvs + comps;
    end

    // next sample selection from the profile state
    always_comb
    begin
        i2      = (phase_reg == PH_ACCEL) ? '0 : idx_reg;
        i3      = (phase_reg == PH_DECEL) ? idx_reg : SW'(1);
        r_kind  = KD_FIN;
        r_i     = '0;
        r_phase = PH_IDLE;
        r_idx   = '0;
        r_done  = 1'b1;
        if ((phase_reg == PH_ACCEL) && (idx_reg < as_reg))
        begin
            r_kind  = KD_ACC;
            r_i     = idx_reg;
            r_phase = PH_ACCEL;
            r_idx   = idx_reg + 1'b1;
            r_done  = done_reg;
        end
        else if ((phase_reg != PH_DECEL) && (i2 < hs_reg))
        begin
            r_kind  = KD_HOLD;
            r_i     = i2;
            r_phase = PH_HOLD;
            r_idx   = i2 + 1'b1;
            r_done  = done_reg;
        end
        else if (i3 < as_reg)
        begin
            r_kind  = KD_DEC;
            r_i     = i3;
            r_phase = PH_DECEL;
            r_idx   = i3 + 1'b1;
            r_done  = done_reg;
        end
    end

    // operands of each step
    always_comb
    begin
        unit_sel = U_NONE;
        op_a     = '0;
        op_b     = '0;
        case (st_reg)
            ST_P_MH:  begin unit_sel = U_MUL;  op_a = DW'(mag);      op_b = DW'(hbw_reg); end
            ST_P_PI:  begin unit_sel = U_MUL;  op_a = tmp_reg;
                            op_b = ttpt_pkg::PI_2880_Q32; end
            ST_P_DA:  begin unit_sel = U_MUL;  op_a = DW'(total_reg); op_b = DW'(a_nz); end
            ST_P_VV:  begin unit_sel = U_MUL;  op_a = DW'(vc_nz);     op_b = DW'(vc_nz); end
            ST_T_VU:  begin unit_sel = U_MUL;  op_a = DW'(vc_nz);     op_b = ttpt_pkg::USEC; end
            ST_T_TAU: begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = DW'(a_nz); end
            ST_T_AD:  begin unit_sel = U_DIV;  op_a = vv_reg;         op_b = DW'({a_nz, 1'b0}); end
            ST_T_RU:  begin unit_sel = U_MUL;
                            op_a = DW'(total_reg) - DW'({ad_reg, 1'b0});
                            op_b = ttpt_pkg::USEC; end
            ST_T_VD:  begin unit_sel = U_MUL;  op_a = DW'(vc_nz);     op_b = DW'(dt_nz); end
            ST_T_N:   begin unit_sel = U_DIV;
                            op_a = tmp_reg + DW'(vd_reg) - DW'(1);
                            op_b = DW'(vd_reg); end
            ST_S_PK:  begin unit_sel = U_SQRT; op_a = da_reg; end
            ST_S_E1:  begin unit_sel = U_MUL;  op_a = DW'(total_reg); op_b = ttpt_pkg::USEC; end
            ST_S_E2:  begin unit_sel = U_MUL;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC; end
            ST_S_E3:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = DW'(a_nz); end
            ST_S_TAU: begin unit_sel = U_SQRT; op_a = tmp_reg; end
            ST_P_AS:  begin unit_sel = U_DIV;
                            op_a = DW'(durs) + DW'(dt_nz) - DW'(1);
                            op_b = DW'(dt_nz); end
            ST_K_T:   begin unit_sel = U_MUL;  op_a = DW'(dt_nz);     op_b = DW'(i_reg); end
            ST_K_HV:  begin unit_sel = U_MUL;  op_a = DW'(vc_nz);     op_b = DW'(t_reg); end
            ST_K_HD:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC; end
            ST_K_AT:  begin unit_sel = U_MUL;  op_a = DW'(a_nz);      op_b = DW'(t_reg); end
            ST_K_AV:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC; end
            ST_K_AVT: begin unit_sel = U_MUL;  op_a = DW'(v_reg);     op_b = DW'(t_reg); end
            ST_K_AD:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC2; end
            ST_K_DU:  begin unit_sel = U_MUL;  op_a = DW'(a_nz);      op_b = DW'(u_reg); end
            ST_K_DW:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC; end
            ST_K_DWU: begin unit_sel = U_MUL;  op_a = tmp_reg;        op_b = DW'(u_reg); end
            ST_K_DD:  begin unit_sel = U_DIV;  op_a = tmp_reg;        op_b = ttpt_pkg::USEC2; end
            ST_K_AC1: begin unit_sel = U_MUL;  op_a = DW'(dmag);      op_b = DW'(hbw_reg); end
            ST_K_AC2: begin unit_sel = U_MUL;  op_a = tmp_reg;
                            op_b = ttpt_pkg::PI_2880_Q32; end
            ST_K_RV:  begin unit_sel = U_MUL;  op_a = DW'(v_reg);     op_b = DW'(rgain_reg); end
            ST_K_CP:  begin unit_sel = U_MUL;  op_a = DW'(emag);      op_b = DW'(pgain_reg); end
            default:  begin unit_sel = U_NONE; end
        endcase
    end

    // result of the running unit
    always_comb
    begin
        case (unit_sel)
            U_MUL:   res = mul_prod;
            U_DIV:   res = div_quot;
            U_SQRT:  res = sqrt_root;
            default: res = '0;
        endcase
        res_rnd = res + ttpt_pkg::ROUND_HALF;
    end

    assign unit_start = (unit_sel != U_NONE) && !busy_reg;
    assign unit_done  = mul_done || div_done || sqrt_done;

    ttpt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start && (unit_sel == U_MUL)),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ttpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start && (unit_sel == U_DIV)),
        .num   (op_a),
        .den   (op_b),
        .done  (div_done),
        .quot  (div_quot)
    );

    ttpt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start && (unit_sel == U_SQRT)),
        .x     (op_a),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_angle_reg <= 14'd0;
            cruise_reg     <= 16'd256;
            accel_reg      <= 16'd256;
            period_reg     <= 17'd20000;
            hbw_reg        <= 14'd3072;
            pgain_reg      <= 16'd0;
            rgain_reg      <= 16'd256;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ttpt_pkg::REG_TURN_ANGLE:    turn_angle_reg <= wr_data[13:0];
                ttpt_pkg::REG_CRUISE_VEL:    cruise_reg     <= wr_data[15:0];
                ttpt_pkg::REG_MAX_ACCEL:     accel_reg      <= wr_data[15:0];
                ttpt_pkg::REG_TICK_PERIOD:   period_reg     <= wr_data;
                ttpt_pkg::REG_HALF_BASE:     hbw_reg        <= wr_data[13:0];
                ttpt_pkg::REG_POSITION_GAIN: pgain_reg      <= wr_data[15:0];
                ttpt_pkg::REG_RPM_GAIN:      rgain_reg      <= wr_data[15:0];
                default:                     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            busy_reg      <= 1'b0;
            zero_reg      <= 1'b1;
            start_yaw_reg <= '0;
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            as_reg        <= '0;
            hs_reg        <= '0;
            peak_reg      <= '0;
            adur_reg      <= '0;
            ad_reg        <= '0;
            total_reg     <= '0;
            turn_left_reg <= 1'b0;
            done_reg      <= 1'b0;
            yaw_reg       <= '0;
            kind_reg      <= KD_FIN;
            i_reg         <= '0;
            tmp_reg       <= '0;
            da_reg        <= '0;
            vv_reg        <= '0;
            vd_reg        <= '0;
            tau_reg       <= '0;
            t_reg         <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            d_reg         <= '0;
            act_reg       <= '0;
            rvm_reg       <= '0;
            cm_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && (st_reg != ST_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (unit_start)
            begin
                busy_reg <= 1'b1;
            end

            case (st_reg)
                // request beat intake
                ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        yaw_reg <= req_item.gyro_yaw;
                        if (req_item.req_type == ttpt_pkg::REQ_START)
                        begin
                            start_yaw_reg <= req_item.gyro_yaw;
                            turn_left_reg <= ang[13];
                            phase_reg     <= PH_ACCEL;
                            idx_reg       <= '0;
                            done_reg      <= 1'b0;
                            zero_reg      <= 1'b1;
                            st_reg        <= ST_P_MH;
                        end
                        else if (req_item.req_type == ttpt_pkg::REQ_TICK)
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                phase_reg <= r_phase;
                                idx_reg   <= r_idx;
                                done_reg  <= r_done;
                                kind_reg  <= r_kind;
                                i_reg     <= r_i;
                                zero_reg  <= 1'b0;
                                st_reg    <= ST_K_T;
                            end
                            else
                            begin
                                zero_reg <= 1'b1;
                                st_reg   <= ST_OUT;
                            end
                        end
                        else
                        begin
                            phase_reg <= PH_IDLE;
                            idx_reg   <= '0;
                            zero_reg  <= 1'b1;
                            st_reg    <= ST_OUT;
                        end
                    end
                end

                // result beat load
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_item_reg.finished  <= done_reg;
                        if (zero_reg)
                        begin
                            rsp_item_reg.left_rpm  <= '0;
                            rsp_item_reg.right_rpm <= '0;
                        end
                        else
                        begin
                            rsp_item_reg.left_rpm  <= ttpt_pkg::sat16(total_sum);
                            rsp_item_reg.right_rpm <= ttpt_pkg::sat16(-total_sum);
                        end
                        st_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    if (unit_done)
                    begin
                        busy_reg <= 1'b0;
                        case (st_reg)
                            // planning
                            ST_P_MH:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_P_PI;
                            end
                            ST_P_PI:
                            begin
                                total_reg <= res_rnd[55:32];
                                st_reg    <= ST_P_DA;
                            end
                            ST_P_DA:
                            begin
                                da_reg <= res;
                                st_reg <= ST_P_VV;
                            end
                            ST_P_VV:
                            begin
                                vv_reg <= res;
                                if (da_reg > res)
                                begin
                                    peak_reg <= vc_nz;
                                    st_reg   <= ST_T_VU;
                                end
                                else
                                begin
                                    st_reg <= ST_S_PK;
                                end
                            end
                            ST_T_VU:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_T_TAU;
                            end
                            ST_T_TAU:
                            begin
                                tau_reg <= res[39:0];
                                st_reg  <= ST_T_AD;
                            end
                            ST_T_AD:
                            begin
                                ad_reg <= res[23:0];
                                st_reg <= ST_T_RU;
                            end
                            ST_T_RU:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_T_VD;
                            end
                            ST_T_VD:
                            begin
                                vd_reg <= res[32:0];
                                st_reg <= ST_T_N;
                            end
                            ST_T_N:
                            begin
                                if (res >= DW'(ttpt_pkg::SEG_MAX))
                                begin
                                    hs_reg <= ttpt_pkg::SEG_MAX;
                                end
                                else
                                begin
                                    hs_reg <= res[SW-1:0] + 1'b1;
                                end
                                st_reg <= ST_P_AS;
                            end
                            ST_S_PK:
                            begin
                                peak_reg <= res[15:0];
                                st_reg   <= ST_S_E1;
                            end
                            ST_S_E1:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_S_E2;
                            end
                            ST_S_E2:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_S_E3;
                            end
                            ST_S_E3:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_S_TAU;
                            end
                            ST_S_TAU:
                            begin
                                tau_reg <= res[39:0];
                                ad_reg  <= total_reg >> 1;
                                hs_reg  <= '0;
                                st_reg  <= ST_P_AS;
                            end
                            ST_P_AS:
                            begin
                                adur_reg <= durs;
                                if (res >= DW'(ttpt_pkg::SEG_MAX))
                                begin
                                    as_reg <= ttpt_pkg::SEG_MAX;
                                end
                                else
                                begin
                                    as_reg <= res[SW-1:0];
                                end
                                st_reg <= ST_OUT;
                            end

                            // tick sample
                            ST_K_T:
                            begin
                                t_reg <= res[29:0];
                                case (kind_reg)
                                    KD_FIN:
                                    begin
                                        v_reg  <= '0;
                                        d_reg  <= 40'(total_reg);
                                        st_reg <= ST_K_AC1;
                                    end
                                    KD_HOLD: st_reg <= ST_K_HV;
                                    default: st_reg <= ST_K_AT;
                                endcase
                            end
                            ST_K_HV:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_HD;
                            end
                            ST_K_HD:
                            begin
                                d_reg  <= 40'(ad_reg) + {1'b0, res[38:0]};
                                v_reg  <= peak_reg;
                                st_reg <= ST_K_AC1;
                            end
                            ST_K_AT:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_AV;
                            end
                            ST_K_AV:
                            begin
                                if (kind_reg == KD_ACC)
                                begin
                                    v_reg  <= (res > DW'(peak_reg)) ? peak_reg : res[15:0];
                                    st_reg <= ST_K_AVT;
                                end
                                else
                                begin
                                    v_reg  <= (res > DW'(peak_reg)) ? 16'd0
                                                                    : peak_reg - res[15:0];
                                    u_reg  <= (30'(adur_reg) > t_reg) ? 30'(adur_reg) - t_reg
                                                                      : t_reg - 30'(adur_reg);
                                    st_reg <= ST_K_DU;
                                end
                            end
                            ST_K_AVT:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_AD;
                            end
                            ST_K_AD:
                            begin
                                d_reg  <= {1'b0, res[38:0]};
                                st_reg <= ST_K_AC1;
                            end
                            ST_K_DU:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_DW;
                            end
                            ST_K_DW:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_DWU;
                            end
                            ST_K_DWU:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_DD;
                            end
                            ST_K_DD:
                            begin
                                d_reg  <= 40'(total_reg) - {1'b0, res[38:0]};
                                st_reg <= ST_K_AC1;
                            end
                            ST_K_AC1:
                            begin
                                tmp_reg <= res;
                                st_reg  <= ST_K_AC2;
                            end
                            ST_K_AC2:
                            begin
                                act_reg <= res_rnd[52:32];
                                st_reg  <= ST_K_RV;
                            end
                            ST_K_RV:
                            begin
                                rvm_reg <= res[31:16];
                                st_reg  <= ST_K_CP;
                            end
                            ST_K_CP:
                            begin
                                cm_reg <= res[57:16];
                                st_reg <= ST_OUT;
                            end
                            default:
                            begin
                                st_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // a unit only reports completion while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n) unit_done |-> busy_reg)
        else $error("arithmetic unit finished with no step waiting");

    // at most one arithmetic unit reports completion at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, div_done, sqrt_done}))
        else $error("more than one arithmetic unit finished together");

    // a stop beat leaves the profiler idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_item.req_type != ttpt_pkg::REQ_START)
                 && (req_item.req_type != ttpt_pkg::REQ_TICK))
        |=> (phase_reg == PH_IDLE))
        else $error("profiler not idle after stop");

    // a result beat appears only out of the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(st_reg) == ST_OUT))
        else $error("result beat raised outside the output step");

endmodule

`default_nettype wire
